[src/bpc_pkg.sv]
package bpc_pkg;

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_SHORT   = 3'd2,
        EV_LONG    = 3'd3,
        EV_DIM     = 3'd4
    } ev_code_t;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_SHORT    = 2'd1,
        CFG_REPEAT   = 2'd2
    } cfg_idx_t;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] SHORT_RST    = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd200;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic     two;
        ev_code_t code0;
        ev_code_t code1;
    } bpc_entry_t;

endpackage

[src/bpc_front.sv]
module bpc_front #(
    parameter int TIME_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    input  logic                     accept,
    input  logic                     pin_level,
    output logic                     push,
    output bpc_pkg::bpc_entry_t      push_data
);
    import bpc_pkg::*;

    localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam logic [CW-1:0] TMAX_W = CW'(TMAX);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_WAIT   = 3'b010,
        PH_REPEAT = 3'b100
    } phase_t;

    logic [CFG_W-1:0]     debounce_reg, short_reg, repeat_reg;
    logic                 level_reg, level_next;
    logic [TIME_BITS-1:0] tsc_reg, tsc_next;
    logic [TIME_BITS-1:0] hold_reg, hold_next;
    logic [TIME_BITS-1:0] cd_reg, cd_next;
    phase_t               phase_reg, phase_next;

    logic [TIME_BITS-1:0] elapsed, held;
    logic                 change, is_short;

    function automatic logic [TIME_BITS-1:0] sat_load(input logic [CFG_W-1:0] v);
        logic [CW-1:0] vx;
        vx = CW'(v);
        return (vx > TMAX_W) ? TMAX : vx[TIME_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            short_reg    <= SHORT_RST;
            repeat_reg   <= REPEAT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_SHORT:    short_reg    <= cfg_data;
                CFG_REPEAT:   repeat_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign elapsed  = (tsc_reg == TMAX) ? tsc_reg : tsc_reg + 1'b1;
    assign held     = (hold_reg == TMAX) ? hold_reg : hold_reg + 1'b1;
    assign change   = (pin_level != level_reg) && (CW'(elapsed) > CW'(debounce_reg));
    assign is_short = CW'(held) <= CW'(short_reg);

    always_comb
    begin
        level_next = level_reg;
        tsc_next   = tsc_reg;
        hold_next  = hold_reg;
        cd_next    = cd_reg;
        phase_next = phase_reg;
        push       = 1'b0;
        push_data  = '{two: 1'b0, code0: EV_PRESS, code1: EV_PRESS};
        if (accept)
        begin
            if (change)
            begin
                level_next = pin_level;
                tsc_next   = '0;
                hold_next  = '0;
                push       = 1'b1;
                if (pin_level)
                begin
                    push_data.code0 = EV_PRESS;
                    phase_next      = PH_WAIT;
                    cd_next         = sat_load(short_reg);
                end
                else
                begin
                    push_data.two   = 1'b1;
                    push_data.code0 = EV_RELEASE;
                    push_data.code1 = is_short ? EV_SHORT : EV_LONG;
                    phase_next      = PH_IDLE;
                    cd_next         = '0;
                end
            end
            else
            begin
                tsc_next = elapsed;
                if (level_reg)
                    hold_next = held;
                unique case (phase_reg)
                    PH_WAIT, PH_REPEAT:
                    begin
                        if (cd_reg <= TIME_BITS'(1))
                        begin
                            push            = 1'b1;
                            push_data.code0 = EV_DIM;
                            phase_next      = PH_REPEAT;
                            cd_next         = sat_load(repeat_reg);
                        end
                        else
                            cd_next = cd_reg - 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        cd_next    = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            tsc_reg   <= TMAX;
            hold_reg  <= '0;
            cd_reg    <= '0;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            level_reg <= level_next;
            tsc_reg   <= tsc_next;
            hold_reg  <= hold_next;
            cd_reg    <= cd_next;
            phase_reg <= phase_next;
        end
    end

    a_timer_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> level_reg)
        else $error("hold timer running while released");

    a_two_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.two) |-> (push_data.code0 == EV_RELEASE && !pin_level))
        else $error("paired events outside a release");

endmodule

[src/bpc_queue.sv]
module bpc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bpc_pkg::bpc_entry_t push_data,
    input  logic                pop,
    output logic                head_valid,
    output bpc_pkg::bpc_entry_t head_data,
    output logic                full
);
    import bpc_pkg::*;

    bpc_entry_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

[src/bpc_back.sv]
module bpc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  bpc_pkg::bpc_entry_t head_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          event_code,
    output logic                last_event
);
    import bpc_pkg::*;

    logic     ov_reg, ov_next;
    ev_code_t code_reg, code_next;
    logic     last_reg, last_next;
    logic     pend_reg, pend_next;
    ev_code_t pcode_reg, pcode_next;
    logic     load;

    assign load = !ov_reg || !out_stall;
    assign pop  = load && !pend_reg && head_valid;

    always_comb
    begin
        ov_next    = ov_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        pend_next  = pend_reg;
        pcode_next = pcode_reg;
        if (load)
        begin
            priority if (pend_reg)
            begin
                ov_next   = 1'b1;
                code_next = pcode_reg;
                last_next = 1'b1;
                pend_next = 1'b0;
            end
            else if (head_valid)
            begin
                ov_next    = 1'b1;
                code_next  = head_data.code0;
                last_next  = !head_data.two;
                pend_next  = head_data.two;
                pcode_next = head_data.code1;
            end
            else
                ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            ov_reg   <= ov_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        last_reg  <= last_next;
        pcode_reg <= pcode_next;
    end

    assign out_valid  = ov_reg;
    assign event_code = code_reg;
    assign last_event = last_reg;

    a_pend_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (ov_reg && !last_reg && code_reg == EV_RELEASE))
        else $error("second event without its first");

endmodule

[src/button_press_classifier_unit.sv]
// A result passes the event queue, then the output register, before it appears.
// One sample per cycle unless the queue is full; a release gives two events in turn.
// A 4-entry event queue lets the sampler run on while the output is stalled.
// Configuration writes are taken every cycle (cfg_ready is always high).
// Reset (async, active low): registers to 50/500/200, level released, queue empty.
module button_press_classifier_unit #(
    parameter int TIME_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        pin_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_code,
    output logic        last_event
);
    import bpc_pkg::*;

    logic       q_full, q_push, q_pop, q_valid, accept;
    bpc_entry_t q_in, q_head;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    bpc_front #(
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pin_level (pin_level),
        .push      (q_push),
        .push_data (q_in)
    );

    bpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head),
        .full       (q_full)
    );

    bpc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code),
        .last_event (last_event)
    );

endmodule

[test/button_press_classifier_unit_tb.sv]
module button_press_classifier_unit_tb;

    import bpc_pkg::*;

    localparam int TIME_BITS = 16;
    localparam logic [TIME_BITS-1:0] TIME_SAT = '1;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RANDOM_PHASES = 8;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_REPEAT = 2'd2
    } timer_phase_t;

    typedef struct {
        ev_code_t code;
        logic     is_last;
    } bpc_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_DEBOUNCE;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        pin_level = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_code;
    logic        last_event;

    // predicted block state and register copies
    logic [15:0]          debounce_reg = DEBOUNCE_RST;
    logic [15:0]          short_reg = SHORT_RST;
    logic [15:0]          repeat_reg = REPEAT_RST;
    logic                 stable_level = 1'b0;
    logic [TIME_BITS-1:0] since_change = TIME_SAT;
    logic [TIME_BITS-1:0] held_for = '0;
    timer_phase_t         dim_phase = PH_IDLE;
    logic [TIME_BITS-1:0] dim_countdown = '0;

    logic       sample_queue[$];
    bpc_event_t pending_events[$];
    bpc_event_t want;

    logic sample_taken = 1'b0;
    bit   steady = 1'b0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   rx_hold_left = 0;
    int   errors = 0;
    int   samples_seen = 0;
    int   reg_writes = 0;
    int   code_count[5];

    button_press_classifier_unit #(
        .TIME_BITS(TIME_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pin_level(pin_level),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_code(event_code),
        .last_event(last_event)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 100)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic push_event(input ev_code_t code, input logic is_last);
        bpc_event_t ev;
        ev.code = code;
        ev.is_last = is_last;
        pending_events.push_back(ev);
    endtask

    task automatic classify_sample(input logic level);
        logic [TIME_BITS-1:0] elapsed;
        logic [TIME_BITS-1:0] held;
        elapsed = (since_change == TIME_SAT) ? TIME_SAT : since_change + 1'b1;
        held = (held_for == TIME_SAT) ? TIME_SAT : held_for + 1'b1;
        if (level != stable_level && elapsed > debounce_reg) begin
            stable_level = level;
            since_change = '0;
            held_for = '0;
            if (level) begin
                push_event(EV_PRESS, 1'b1);
                dim_phase = PH_FIRST;
                dim_countdown = short_reg;
            end
            else begin
                push_event(EV_RELEASE, 1'b0);
                push_event((held <= short_reg) ? EV_SHORT : EV_LONG, 1'b1);
                dim_phase = PH_IDLE;
                dim_countdown = '0;
            end
        end
        else begin
            since_change = elapsed;
            if (stable_level)
                held_for = held;
            if (dim_phase == PH_FIRST || dim_phase == PH_REPEAT) begin
                if (dim_countdown <= 1) begin
                    push_event(EV_DIM, 1'b1);
                    dim_phase = PH_REPEAT;
                    dim_countdown = repeat_reg;
                end
                else begin
                    dim_countdown = dim_countdown - 1'b1;
                end
            end
            else begin
                dim_phase = PH_IDLE;
                dim_countdown = '0;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: present the next sample once the current transaction is taken
    always @(negedge clk) begin
        if (!in_valid || sample_taken) begin
            if (tx_gap > 0) begin
                in_valid <= 1'b0;
                tx_gap--;
            end
            else if (sample_queue.size() > 0) begin
                in_valid <= 1'b1;
                pin_level <= sample_queue.pop_front();
                tx_gap = steady ? 0 : pick_gap();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a forced hold-off when requested
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end
        else if (steady) begin
            out_stall <= 1'b0;
        end
        else if (rx_gap > 0) begin
            out_stall <= 1'b1;
            rx_gap--;
        end
        else begin
            out_stall <= 1'b0;
            rx_gap = pick_gap();
        end
    end

    // monitor: predict on accepted samples, check accepted events
    always @(posedge clk) begin
        sample_taken = rst_n && in_valid && !in_stall;
        if (sample_taken) begin
            samples_seen++;
            classify_sample(pin_level);
        end
        if (rst_n && out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event code %0d", event_code));
            end
            else begin
                want = pending_events.pop_front();
                if (event_code <= 3'd4)
                    code_count[event_code]++;
                if (event_code !== want.code)
                    report_mismatch($sformatf("event_code %0d, want %0d (%s)",
                        event_code, want.code, want.code.name()));
                if (last_event !== want.is_last)
                    report_mismatch($sformatf("last_event %0b, want %0b on %s",
                        last_event, want.is_last, want.code.name()));
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE: debounce_reg = value;
            CFG_SHORT:    short_reg = value;
            CFG_REPEAT:   repeat_reg = value;
            default:      ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] deb, input logic [15:0] shrt,
                             input logic [15:0] rpt);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_SHORT, shrt);
        write_reg(CFG_REPEAT, rpt);
    endtask

    task automatic wait_idle();
        int k;
        while (sample_queue.size() > 0 || in_valid)
            @(posedge clk);
        for (k = 0; k < DRAIN_LIMIT && pending_events.size() > 0; k++)
            @(posedge clk);
        if (pending_events.size() > 0) begin
            report_mismatch($sformatf("%0d expected events never arrived",
                pending_events.size()));
            pending_events.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_levels(input logic [31:0] bits, input int count);
        int k;
        for (k = count - 1; k >= 0; k--)
            sample_queue.push_back(bits[k]);
    endtask

    task automatic queue_bouncy_runs(input int count, input int max_run, input int glitch_pct);
        int added;
        int run;
        logic level;
        added = 0;
        level = 1'($urandom_range(0, 1));
        while (added < count) begin
            run = $urandom_range(1, max_run);
            repeat (run) sample_queue.push_back(level);
            added += run;
            if ($urandom_range(0, 99) < glitch_pct) begin
                sample_queue.push_back(~level);
                added++;
            end
            level = ~level;
        end
    endtask

    function automatic logic [15:0] pick_debounce();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 16'd0;
        if (r < 8)
            return 16'($urandom_range(1, 6));
        return 16'($urandom_range(15, 30));
    endfunction

    function automatic logic [15:0] pick_delay(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 16'd0;
        if (r < 25)
            return 16'd1;
        if (r < 92)
            return 16'($urandom_range(2, 12));
        return 16'hFFFF;
    endfunction

    initial begin
        int p;
        int max_run;
        logic [15:0] deb;
        logic [15:0] shrt;
        logic [15:0] rpt;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // defaults: first press accepted, early release swallowed by debounce
        queue_levels(32'b1001, 4);
        wait_idle();

        // no debounce, tiny delays, zero repeat interval, ignored register index
        configure(16'd0, 16'd2, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        queue_levels(32'b011111010110110, 15);
        wait_idle();

        // debounce at counter maximum locks the level
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        queue_levels(32'b101, 3);
        wait_idle();

        // fill the event queue while the receiver holds off
        configure(16'd0, 16'd1, 16'd1);
        @(posedge clk);
        rx_hold_left = 60;
        sample_queue.push_back(1'b0);
        repeat (30) sample_queue.push_back(1'b1);
        sample_queue.push_back(1'b0);
        wait_idle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            deb = pick_debounce();
            shrt = pick_delay(8);
            rpt = pick_delay(12);
            configure(deb, shrt, rpt);
            steady = (p % 4 == 3);
            max_run = deb + ((shrt > 16'd30) ? 30 : shrt) + 4;
            if (max_run > 40)
                max_run = 40;
            queue_bouncy_runs(40, max_run, 20);
            wait_idle();
        end

        // long hold: first dim, several repeats, then a long press
        steady = 1'b1;
        configure(16'd0, 16'd20, 16'd3);
        sample_queue.push_back(1'b0);
        repeat (40) sample_queue.push_back(1'b1);
        sample_queue.push_back(1'b0);
        wait_idle();

        $display("Summary: %0d samples, %0d register writes, %0d mismatches",
            samples_seen, reg_writes, errors);
        $display("Events: press %0d, release %0d, short %0d, long %0d, dim %0d",
            code_count[EV_PRESS], code_count[EV_RELEASE], code_count[EV_SHORT],
            code_count[EV_LONG], code_count[EV_DIM]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[button_press_classifier_unit.f]
src/bpc_pkg.sv
src/bpc_front.sv
src/bpc_queue.sv
src/bpc_back.sv
src/button_press_classifier_unit.sv
test/button_press_classifier_unit_tb.sv
